// ----- sv/qpht_pkg.sv -----
// ---------------------------------------------------------------------------
// qpht_pkg
// Types, command codes, slot states and status codes for the hash table.
// ---------------------------------------------------------------------------
package qpht_pkg;

    localparam int KEY_LO_W = 48;
    localparam int KEY_HI_W = 40;
    localparam int BAL_W    = 32;
    localparam int CNT_W    = 18;
    localparam int NCHAR    = 21;
    localparam int NNIB     = 17;   // digit characters, 4 bits each

    typedef enum logic [2:0] {
        CMD_CREATE = 3'd0,
        CMD_GET    = 3'd1,
        CMD_ADD    = 3'd2,
        CMD_EXISTS = 3'd3,
        CMD_DELETE = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        SLOT_EMPTY = 2'd0,
        SLOT_USED  = 2'd1,
        SLOT_TOMB  = 2'd2
    } slot_st_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

endpackage

// ----- sv/qpht_hash.sv -----
// ---------------------------------------------------------------------------
// qpht_hash
// Home slot: sum of char * 31^i mod size, Horner form, one char at a time.
// ---------------------------------------------------------------------------
module qpht_hash
    import qpht_pkg::*;
#(
    parameter int TABLE_SIZE = 65521,
    parameter int IDX_W      = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [19:0]      key_letters,
    input  logic [27:0]      key_digits_mid,
    input  logic [39:0]      key_digits_tail,
    output logic             done,
    output logic [IDX_W-1:0] home
);

    localparam int            CW = IDX_W + 6;
    localparam logic [CW-1:0] SZ = CW'(TABLE_SIZE);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [4:0]       pos_reg, pos_next;
    logic [2:0]       ph_reg, ph_next;
    logic [CW-1:0]    acc_reg, acc_next;
    logic [87:0]      key_reg, key_next;
    logic [4:0]       ch;
    logic [CW-1:0]    sub;

    // chars taken from the bottom: 17 digits (4b), then 4 letters (5b)
    // acc = acc * 31 + ch, then reduce by 16, 8, 4, 2, 1 x size
    always_comb
    begin
        if (pos_reg < 5'(NNIB))
            ch = {1'b0, key_reg[3:0]};
        else
            ch = key_reg[4:0];
        sub = SZ << (3'd5 - ph_reg);
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        pos_next  = pos_reg;
        ph_next   = ph_reg;
        acc_next  = acc_reg;
        key_next  = key_reg;
        if (start)
        begin
            busy_next = 1'b1;
            pos_next  = '0;
            ph_next   = '0;
            acc_next  = '0;
            key_next  = {key_letters, key_digits_mid, key_digits_tail};
        end
        else if (busy_reg)
        begin
            if (ph_reg == 3'd0)
            begin
                acc_next = (acc_reg << 5) - acc_reg + CW'(ch);
                ph_next  = 3'd1;
            end
            else
            begin
                if (acc_reg >= sub)
                    acc_next = acc_reg - sub;
                ph_next = ph_reg + 3'd1;
                if (ph_reg == 3'd5)
                begin
                    ph_next  = '0;
                    pos_next = pos_reg + 5'd1;
                    key_next = (pos_reg < 5'(NNIB)) ? {4'd0, key_reg[87:4]}
                                                    : {5'd0, key_reg[87:5]};
                    if (pos_reg == 5'(NCHAR - 1))
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
            end
        end
    end

    assign done = done_reg;
    assign home = IDX_W'(acc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        ph_reg  <= ph_next;
        acc_reg <= acc_next;
        key_reg <= key_next;
    end

endmodule

// ----- sv/qpht_store.sv -----
// ---------------------------------------------------------------------------
// qpht_store
// Slot memories: state, key and balance, one read and one write port.
// ---------------------------------------------------------------------------
module qpht_store
    import qpht_pkg::*;
#(
    parameter int TABLE_SIZE = 65521,
    parameter int IDX_W      = 16
)
(
    input  logic                clk,
    input  logic [IDX_W-1:0]    raddr,
    output slot_st_t            rd_st,
    output logic [KEY_LO_W-1:0] rd_klo,
    output logic [KEY_HI_W-1:0] rd_khi,
    output logic [BAL_W-1:0]    rd_bal,
    input  logic                we_st,
    input  logic                we_all,
    input  logic [IDX_W-1:0]    waddr,
    input  slot_st_t            wr_st,
    input  logic [KEY_LO_W-1:0] wr_klo,
    input  logic [KEY_HI_W-1:0] wr_khi,
    input  logic [BAL_W-1:0]    wr_bal
);

    logic [1:0]          st_mem  [TABLE_SIZE];
    logic [KEY_LO_W-1:0] klo_mem [TABLE_SIZE];
    logic [KEY_HI_W-1:0] khi_mem [TABLE_SIZE];
    logic [BAL_W-1:0]    bal_mem [TABLE_SIZE];

    always_ff @(posedge clk)
    begin
        if (we_st)
            st_mem[waddr] <= wr_st;
        if (we_all)
        begin
            klo_mem[waddr] <= wr_klo;
            khi_mem[waddr] <= wr_khi;
            bal_mem[waddr] <= wr_bal;
        end
        rd_st  <= slot_st_t'(st_mem[raddr]);
        rd_klo <= klo_mem[raddr];
        rd_khi <= khi_mem[raddr];
        rd_bal <= bal_mem[raddr];
    end

endmodule

// ----- sv/quadratic_probe_hash_table.sv -----
// ---------------------------------------------------------------------------
// quadratic_probe_hash_table
// Open-addressing account table with quadratic probing and tombstones.
// ---------------------------------------------------------------------------
// Sequence: accept, hash of the 21-char key, then a read and a check per probe,
// then S_DONE and S_OUT; add on a missing key walks twice; a bad command goes
// from the hash straight to S_OUT. One request at a time; the next is accepted
// in S_IDLE once the result is loaded; a stalled older result holds the new one
// in S_OUT. Reset: clearing pass writes every slot state empty, with in_stall
// held high; live count resets to zero.
// ---------------------------------------------------------------------------
module quadratic_probe_hash_table
    import qpht_pkg::*;
#(
    parameter int TABLE_SIZE = 65521
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         cmd,
    input  logic [19:0]        key_letters,
    input  logic [27:0]        key_digits_mid,
    input  logic [39:0]        key_digits_tail,
    input  logic signed [31:0] amount,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               found,
    output logic signed [31:0] balance_out,
    output logic [17:0]        live_count,
    output logic [1:0]         status
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int XW    = IDX_W;
    localparam logic [IDX_W:0] SZ = (IDX_W+1)'(TABLE_SIZE);
    localparam logic [XW-1:0]  XMAX = XW'(TABLE_SIZE / 2);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_HASH  = 7'b0000100,
        S_READ  = 7'b0001000,
        S_CHECK = 7'b0010000,
        S_DONE  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    clr_reg, clr_next;
    logic [2:0]          cmd_reg, cmd_next;
    logic [KEY_LO_W-1:0] klo_reg, klo_next;
    logic [KEY_HI_W-1:0] khi_reg, khi_next;
    logic [BAL_W-1:0]    amt_reg, amt_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;   // current probe slot
    logic [IDX_W-1:0]    step_reg, step_next;   // 2x+1 mod size
    logic [XW-1:0]       x_reg, x_next;
    logic                free_ok_reg, free_ok_next;
    logic [IDX_W-1:0]    free_reg, free_next;
    logic                ins_reg, ins_next;     // walking for insert
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                ov_reg, ov_next;
    logic                f_reg, f_next;
    logic [BAL_W-1:0]    b_reg, b_next;
    logic [1:0]          s_reg, s_next;
    logic                res_f_reg, res_f_next;
    logic [BAL_W-1:0]    res_b_reg, res_b_next;
    logic [CNT_W-1:0]    res_cnt_reg, res_cnt_next;
    logic [1:0]          res_s_reg, res_s_next;

    logic             hash_start, hash_done;
    logic [IDX_W-1:0] home;

    slot_st_t            rd_st;
    logic [KEY_LO_W-1:0] rd_klo;
    logic [KEY_HI_W-1:0] rd_khi;
    logic [BAL_W-1:0]    rd_bal;
    logic                we_st, we_all;
    logic [IDX_W-1:0]    waddr;
    slot_st_t            wr_st;
    logic [BAL_W-1:0]    wr_bal;
    logic [IDX_W:0]      ns, nst;
    logic                hit, last;

    qpht_hash #(.TABLE_SIZE(TABLE_SIZE), .IDX_W(IDX_W)) u_hash
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (hash_start),
        .key_letters     (key_letters),
        .key_digits_mid  (key_digits_mid),
        .key_digits_tail (key_digits_tail),
        .done            (hash_done),
        .home            (home)
    );

    qpht_store #(.TABLE_SIZE(TABLE_SIZE), .IDX_W(IDX_W)) u_store
    (
        .clk    (clk),
        .raddr  (slot_reg),
        .rd_st  (rd_st),
        .rd_klo (rd_klo),
        .rd_khi (rd_khi),
        .rd_bal (rd_bal),
        .we_st  (we_st),
        .we_all (we_all),
        .waddr  (waddr),
        .wr_st  (wr_st),
        .wr_klo (klo_reg),
        .wr_khi (khi_reg),
        .wr_bal (wr_bal)
    );

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = ov_reg;
    assign found       = res_f_reg;
    assign balance_out = res_b_reg;
    assign live_count  = res_cnt_reg;
    assign status      = res_s_reg;
    assign hash_start  = in_valid && (state_reg == S_IDLE);

    always_comb
    begin
        ns   = (IDX_W+1)'(slot_reg) + (IDX_W+1)'(step_reg);
        nst  = (IDX_W+1)'(step_reg) + (IDX_W+1)'(2);
        hit  = (rd_st == SLOT_USED) && (rd_klo == klo_reg) && (rd_khi == khi_reg);
        last = (x_reg == XMAX);
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        cmd_next     = cmd_reg;
        klo_next     = klo_reg;
        khi_next     = khi_reg;
        amt_next     = amt_reg;
        slot_next    = slot_reg;
        step_next    = step_reg;
        x_next       = x_reg;
        free_ok_next = free_ok_reg;
        free_next    = free_reg;
        ins_next     = ins_reg;
        cnt_next     = cnt_reg;
        ov_next      = ov_reg;
        f_next       = f_reg;
        b_next       = b_reg;
        s_next       = s_reg;
        res_f_next   = res_f_reg;
        res_b_next   = res_b_reg;
        res_cnt_next = res_cnt_reg;
        res_s_next   = res_s_reg;
        we_st        = 1'b0;
        we_all       = 1'b0;
        waddr        = slot_reg;
        wr_st        = SLOT_EMPTY;
        wr_bal       = amt_reg;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                we_st    = 1'b1;
                waddr    = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(TABLE_SIZE - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd;
                    klo_next   = {key_letters, key_digits_mid};
                    khi_next   = key_digits_tail;
                    amt_next   = amount;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    slot_next    = home;
                    step_next    = IDX_W'(1 % TABLE_SIZE);
                    x_next       = '0;
                    free_ok_next = 1'b0;
                    ins_next     = (cmd_reg == CMD_CREATE);
                    if (cmd_reg == CMD_CREATE || cmd_reg == CMD_GET || cmd_reg == CMD_ADD
                        || cmd_reg == CMD_EXISTS || cmd_reg == CMD_DELETE)
                        state_next = S_READ;
                    else
                    begin
                        f_next     = 1'b0;
                        b_next     = '1;
                        s_next     = STAT_MISS;
                        state_next = S_OUT;
                    end
                end
            end
            S_READ:
                state_next = S_CHECK;
            S_CHECK:
            begin
                state_next = S_READ;
                slot_next  = (ns >= SZ) ? IDX_W'(ns - SZ) : IDX_W'(ns);
                step_next  = (nst >= SZ) ? IDX_W'(nst - SZ) : IDX_W'(nst);
                x_next     = x_reg + 1'b1;
                if (ins_reg)
                begin
                    if (rd_st != SLOT_USED)
                    begin
                        free_ok_next = 1'b1;
                        free_next    = slot_reg;
                        state_next   = S_DONE;
                    end
                    else if (last)
                        state_next = S_DONE;
                end
                else if (hit)
                begin
                    free_next  = slot_reg;
                    b_next     = rd_bal;
                    f_next     = 1'b1;
                    state_next = S_DONE;
                end
                else if (rd_st == SLOT_EMPTY || last)
                begin
                    f_next     = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_OUT;
                waddr      = free_reg;
                if (ins_reg)
                begin
                    if (free_ok_reg)
                    begin
                        we_st    = 1'b1;
                        we_all   = 1'b1;
                        wr_st    = SLOT_USED;
                        cnt_next = cnt_reg + 1'b1;
                        f_next   = 1'b1;
                        b_next   = amt_reg;
                        s_next   = STAT_OK;
                    end
                    else
                    begin
                        f_next = 1'b0;
                        b_next = '1;
                        s_next = STAT_FULL;
                    end
                end
                else if (f_reg)
                begin
                    s_next = STAT_OK;
                    if (cmd_reg == CMD_ADD)
                    begin
                        wr_bal = b_reg + amt_reg;
                        we_all = 1'b1;
                        we_st  = 1'b1;
                        wr_st  = SLOT_USED;
                        b_next = b_reg + amt_reg;
                    end
                    else if (cmd_reg == CMD_DELETE)
                    begin
                        we_st    = 1'b1;
                        wr_st    = SLOT_TOMB;
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
                else if (cmd_reg == CMD_ADD)
                begin
                    // missing key: restart walk as insert
                    ins_next   = 1'b1;
                    slot_next  = home;
                    step_next  = IDX_W'(1 % TABLE_SIZE);
                    x_next     = '0;
                    state_next = S_READ;
                end
                else
                begin
                    b_next = '1;
                    s_next = STAT_MISS;
                end
            end
            S_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next      = 1'b1;
                    res_f_next   = f_reg;
                    res_b_next   = b_reg;
                    res_cnt_next = cnt_reg;
                    res_s_next   = s_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        klo_reg     <= klo_next;
        khi_reg     <= khi_next;
        amt_reg     <= amt_next;
        slot_reg    <= slot_next;
        step_reg    <= step_next;
        x_reg       <= x_next;
        free_ok_reg <= free_ok_next;
        free_reg    <= free_next;
        ins_reg     <= ins_next;
        f_reg       <= f_next;
        b_reg       <= b_next;
        s_reg       <= s_next;
        res_f_reg   <= res_f_next;
        res_b_reg   <= res_b_next;
        res_cnt_reg <= res_cnt_next;
        res_s_reg   <= res_s_next;
    end

endmodule

// ----- sv/qpht_check.sv -----
// ---------------------------------------------------------------------------
// qpht_check
// Port-level checks on the result channel of the hash table.
// ---------------------------------------------------------------------------
module qpht_check
    import qpht_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        found,
    input logic [31:0] balance_out,
    input logic [17:0] live_count,
    input logic [1:0]  status
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid
            && $stable({found, balance_out, live_count, status}))
        else $error("result dropped under stall");

    a_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (found == (status == STAT_OK)))
        else $error("found and status disagree");

    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> balance_out == 32'hFFFF_FFFF)
        else $error("miss without -1 balance");

    a_stat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("bad status");

endmodule

bind quadratic_probe_hash_table qpht_check u_qpht_check
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .balance_out (balance_out),
    .live_count  (live_count),
    .status      (status)
);
